@@ hdl/six_button_pad_io_ports_top_defines.svh @@
// ----------------------------------------------------------------------------
// Six-button pad I/O ports: assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SIX_BUTTON_PAD_IO_PORTS_TOP_DEFINES_SVH
`define SIX_BUTTON_PAD_IO_PORTS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SBP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbp check failed: same-cycle implication");
// next-cycle implication
`define SBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbp check failed: next-cycle implication");
`else
`define SBP_ASSERT_NOW(lbl, ante, cons)
`define SBP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/sbp_pkg.sv @@
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types and constants of the six-button pad I/O port block.
// ----------------------------------------------------------------------------
package sbp_pkg;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_BUTTON = 2'd3;

    localparam logic [4:0] OFF_REGION = 5'd1;
    localparam logic [4:0] OFF_A_DATA = 5'd3;
    localparam logic [4:0] OFF_B_DATA = 5'd5;
    localparam logic [4:0] OFF_A_DIR  = 5'd9;
    localparam logic [4:0] OFF_B_DIR  = 5'd11;

    localparam logic [1:0] CFG_REGION  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;

    localparam int         NUM_BUTTONS    = 12;
    localparam logic [3:0] BTN_LIMIT      = 4'd12;
    localparam logic [7:0] REGION_RESET   = 8'hA0;
    localparam logic [13:0] TIMEOUT_RESET = 14'd11500;
    localparam logic [7:0] LATCH_RESET    = 8'h7F;
    localparam logic [7:0] TH_MASK        = 8'h40;
    localparam logic [7:0] LOW_NIBBLE     = 8'h0F;
    localparam logic [7:0] UNMAPPED_BYTE  = 8'hFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  offset;
        logic [7:0]  write_data;
        logic [15:0] tick_cycles;
        logic [3:0]  button_index;
        logic        pressed;
    } t_item;

endpackage

@@ hdl/sbp_in_stage.sv @@
// ----------------------------------------------------------------------------
// sbp_in_stage
// Input register: captures one item per transfer, hands it to the core.
// ----------------------------------------------------------------------------
module sbp_in_stage import sbp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  logic  i_fire,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_load;

    assign o_stall = r_valid && !i_fire;
    assign w_load  = i_valid && !o_stall;
    assign n_valid = w_load || (r_valid && !i_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hdl/sbp_core.sv @@
// ----------------------------------------------------------------------------
// sbp_core
// Port latches, direction masks, button lines, strobe phase and timeout.
// Updates state and forms the read byte for the item leaving the input stage.
// ----------------------------------------------------------------------------
module sbp_core import sbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_item       i_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data,
    output logic [7:0]  o_read_data
);

    logic [7:0]             r_region;
    logic [13:0]            r_timeout_cfg;
    logic [7:0]             r_a_latch;
    logic [7:0]             r_b_latch;
    logic [7:0]             r_a_dir;
    logic [7:0]             r_b_dir;
    logic [NUM_BUTTONS-1:0] r_buttons;
    logic [1:0]             r_phase;
    logic [13:0]            r_timeout_left;

    logic [7:0] w_mux;
    logic [7:0] w_port_a;
    logic       w_th;
    logic       w_th_rise;

    assign w_th      = r_a_latch[6];
    assign w_th_rise = !w_th && i_item.write_data[6];

    // TH-selected button group, released buttons read 1
    always_comb begin
        if (w_th) begin
            w_mux = {2'b01, r_buttons[6], r_buttons[5], 4'b0000};
            if (r_phase == 2'd3) begin
                w_mux[3:0] = {r_buttons[11], r_buttons[8], r_buttons[9], r_buttons[10]};
            end else begin
                w_mux[3:0] = {r_buttons[3], r_buttons[2], r_buttons[1], r_buttons[0]};
            end
        end else begin
            w_mux = {2'b00, r_buttons[7], r_buttons[4], 4'b0000};
            if (r_phase == 2'd3) begin
                w_mux = w_mux | LOW_NIBBLE;
            end else if (r_phase != 2'd2) begin
                w_mux[1:0] = {r_buttons[1], r_buttons[0]};
            end
        end
        w_port_a = (w_mux & ~r_a_dir) | (r_a_latch & r_a_dir);
    end

    always_comb begin
        o_read_data = 8'h00;
        if (i_item.kind == KIND_READ) begin
            case (i_item.offset)
                OFF_REGION: o_read_data = r_region;
                OFF_A_DATA: o_read_data = w_port_a;
                OFF_B_DATA: o_read_data = r_b_latch;
                OFF_A_DIR:  o_read_data = r_a_dir;
                OFF_B_DIR:  o_read_data = r_b_dir;
                default:    o_read_data = UNMAPPED_BYTE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region       <= REGION_RESET;
            r_timeout_cfg  <= TIMEOUT_RESET;
            r_a_latch      <= LATCH_RESET;
            r_b_latch      <= LATCH_RESET;
            r_a_dir        <= 8'h00;
            r_b_dir        <= 8'h00;
            r_buttons      <= '1;
            r_phase        <= 2'd0;
            r_timeout_left <= 14'd0;
        end else begin
            if (i_fire) begin
                case (i_item.kind)
                    KIND_WRITE: begin
                        case (i_item.offset)
                            OFF_A_DATA: begin
                                // edge sees the raw write bit, not the masked one
                                if (w_th_rise) begin
                                    r_phase        <= r_phase + 2'd1;
                                    r_timeout_left <= r_timeout_cfg;
                                end
                                r_a_latch <= (r_a_latch & ~r_a_dir)
                                           | (i_item.write_data & r_a_dir);
                            end
                            OFF_B_DATA: r_b_latch <= (r_b_latch & ~r_b_dir)
                                                   | (i_item.write_data & r_b_dir);
                            OFF_A_DIR:  r_a_dir <= i_item.write_data;
                            OFF_B_DIR:  r_b_dir <= i_item.write_data;
                            default: ;
                        endcase
                    end
                    KIND_TICK: begin
                        if (r_timeout_left != 14'd0) begin
                            if (i_item.tick_cycles >= {2'b00, r_timeout_left}) begin
                                r_timeout_left <= 14'd0;
                                r_phase        <= 2'd0;
                            end else begin
                                r_timeout_left <= r_timeout_left - i_item.tick_cycles[13:0];
                            end
                        end
                    end
                    KIND_BUTTON: begin
                        if (i_item.button_index < BTN_LIMIT) begin
                            r_buttons[i_item.button_index] <= !i_item.pressed;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REGION:  r_region      <= i_cfg_data[7:0];
                    CFG_TIMEOUT: r_timeout_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ hdl/sbp_out_stage.sv @@
// ----------------------------------------------------------------------------
// sbp_out_stage
// Result register: holds the read byte until the consumer takes the transfer.
// ----------------------------------------------------------------------------
module sbp_out_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    input  logic       i_stall,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_data
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic       w_load;

    assign o_ready = !r_valid || !i_stall;
    assign w_load  = i_valid && o_ready;
    assign n_valid = w_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hdl/six_button_pad_io_ports_top.sv @@
// Path: an item passes the input register, then the result register once the output
// side is ready. Throughput: one item per cycle unless the output stalls;
// the core state updates in a single pass.
// Reset: synchronous active-low; both stages empty, latches 0x7F, directions 0,
// buttons released, phase and timeout 0, registers at 0xA0 and 11500.
// ----------------------------------------------------------------------------
// six_button_pad_io_ports_top
// Controller I/O port block for a six-button pad with TH strobe multiplexing.
// ----------------------------------------------------------------------------
`include "six_button_pad_io_ports_top_defines.svh"

module six_button_pad_io_ports_top import sbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [4:0]  i_offset,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_tick_cycles,
    input  logic [3:0]  i_button_index,
    input  logic        i_pressed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    t_item      w_in_item;
    t_item      w_item;
    logic       w_item_valid;
    logic       w_out_ready;
    logic       w_fire;
    logic [7:0] w_read_data;

    assign w_in_item = '{kind: i_kind, offset: i_offset, write_data: i_write_data,
                         tick_cycles: i_tick_cycles, button_index: i_button_index,
                         pressed: i_pressed};
    assign w_fire = w_item_valid && w_out_ready;

    sbp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .i_fire  (w_fire),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    sbp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_read_data (w_read_data)
    );

    sbp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fire),
        .i_data  (w_read_data),
        .i_stall (i_out_stall),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_read_data)
    );

    // input side only backs up while an item is parked in the input register
    `SBP_ASSERT_NOW(a_stall_has_item, o_in_stall, w_item_valid)
    // an item leaving the core always lands in the result register
    `SBP_ASSERT_NEXT(a_fire_gives_result, w_fire, o_out_valid)
    // results of non-read items are zero
    `SBP_ASSERT_NEXT(a_nonread_zero, w_fire && (w_item.kind != KIND_READ), o_read_data == 8'h00)

endmodule
